/* sv/pmi_pkg.sv */
// Shared constants and control types for the point-mass integrator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pmi_pkg;

	localparam int unsigned PMI_FRAC_BITS = 16;
	localparam int unsigned PMI_WORD_BITS = 32;

	// time step is always Q0.16
	localparam int unsigned DT_BITS  = 16;
	localparam logic [DT_BITS-1:0] DT_RESET = 16'd655;

	localparam int unsigned REG_IDX_BITS = 3;
	localparam logic [REG_IDX_BITS-1:0] REG_BODY_MASS   = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_TIME_STEP   = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_START_POS_X = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_START_POS_Y = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_START_POS_Z = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_START_VEL_X = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_START_VEL_Y = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_START_VEL_Z = 3'd7;

	localparam int unsigned NUM_AXES  = 3;
	localparam logic [1:0]  AXIS_FIRST = 2'd0;
	localparam logic [1:0]  AXIS_LAST  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic       accept;     // item transfer: restart load and force add
		logic       div_start;  // load divider for current axis
		logic       mul_vel;    // latch accel, product |v|*dt
		logic       mul_acc;    // velocity term, product |a|*dt
		logic       mul_acc2;   // dv term, product |a|*dt*dt
		logic       update;     // write back new position and velocity
		logic       out_load;   // copy state into the result register
		logic [1:0] axis;
	} pmi_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
	} pmi_stat_t;

endpackage

`default_nettype wire

/* sv/pmi_item_if.sv */
// Input channel: force vector plus advance and restart flags.
// Depends on pmi_pkg for the default word width.
`timescale 1ns / 1ps
`default_nettype none

interface pmi_item_if import pmi_pkg::*; #(
	parameter int unsigned WORD_BITS = PMI_WORD_BITS
);
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] force_x;
	logic signed [WORD_BITS-1:0] force_y;
	logic signed [WORD_BITS-1:0] force_z;
	logic                        advance;
	logic                        restart;

	modport source (output valid, force_x, force_y, force_z, advance, restart, input ready);
	modport sink   (input valid, force_x, force_y, force_z, advance, restart, output ready);
endinterface

`default_nettype wire

/* sv/pmi_result_if.sv */
// Output channel: position, velocity and saturation flag.
// Depends on pmi_pkg for the default word width.
`timescale 1ns / 1ps
`default_nettype none

interface pmi_result_if import pmi_pkg::*; #(
	parameter int unsigned WORD_BITS = PMI_WORD_BITS
);
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] pos_x;
	logic signed [WORD_BITS-1:0] pos_y;
	logic signed [WORD_BITS-1:0] pos_z;
	logic signed [WORD_BITS-1:0] vel_x;
	logic signed [WORD_BITS-1:0] vel_y;
	logic signed [WORD_BITS-1:0] vel_z;
	logic                        saturated;

	modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, saturated,
		input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, saturated,
		output ready);
endinterface

`default_nettype wire

/* sv/point_mass_integrator.sv */
// Point-mass integrator, 3-D, signed fixed point (WORD_BITS, FRAC_BITS).
// Without advance an accepted item goes straight to the result register; with
// advance the bit-serial divider and the dt multiply steps run once per axis.
// One item in flight; the next item is taken while a result waits in the
// output register.
// Reset (arst_n low, async): state and force sum zero, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module point_mass_integrator import pmi_pkg::*; #(
	parameter int unsigned FRAC_BITS = PMI_FRAC_BITS,
	parameter int unsigned WORD_BITS = PMI_WORD_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    wr_en,
	input  wire logic [REG_IDX_BITS-1:0] wr_index,
	input  wire logic [WORD_BITS-1:0]    wr_data,
	pmi_item_if.sink                     item,
	pmi_result_if.source                 result
);
	pmi_cmd_t  cmd;
	pmi_stat_t stat;

	pmi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item.valid),
		.in_advance (item.advance),
		.in_ready   (item.ready),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.cmd        (cmd),
		.stat       (stat)
	);

	pmi_dp #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.force_x   (item.force_x),
		.force_y   (item.force_y),
		.force_z   (item.force_z),
		.restart   (item.restart),
		.cmd       (cmd),
		.stat      (stat),
		.pos_x     (result.pos_x),
		.pos_y     (result.pos_y),
		.pos_z     (result.pos_z),
		.vel_x     (result.vel_x),
		.vel_y     (result.vel_y),
		.vel_z     (result.vel_z),
		.saturated (result.saturated)
	);

endmodule

`default_nettype wire

/* sv/pmi_div.sv */
// Restoring divider, one quotient bit per cycle: force * 2^FRAC_BITS / mass,
// saturated to the signed word. Depends on pmi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmi_div import pmi_pkg::*; #(
	parameter int unsigned WORD_BITS = PMI_WORD_BITS,
	parameter int unsigned FRAC_BITS = PMI_FRAC_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic signed [WORD_BITS-1:0] dividend,
	input  wire logic        [WORD_BITS-1:0] divisor,
	output logic                             done,
	output logic                             ovf,
	output logic signed      [WORD_BITS-1:0] quot
);
	localparam int unsigned W  = WORD_BITS;
	localparam int unsigned QW = WORD_BITS + FRAC_BITS;
	localparam int unsigned CW = $clog2(QW + 1);
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

	logic [QW-1:0] sh_q;
	logic [QW-1:0] q_q;
	logic [W-1:0]  r_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic          fzero_q;
	logic          mzero_q;

	logic [W-1:0]  fmag;
	logic [W:0]    r_try;
	logic          ge;
	logic [W:0]    r_sub;
	logic [W-1:0]  mag;
	logic          big;
	logic          over;

	assign fmag  = dividend[W-1] ? W'(-dividend) : W'(dividend);
	assign r_try = {r_q, sh_q[QW-1]};
	assign ge    = r_try >= {1'b0, divisor};
	assign r_sub = r_try - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(QW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q    <= {fmag, {FRAC_BITS{1'b0}}};
			q_q     <= '0;
			r_q     <= '0;
			neg_q   <= dividend[W-1];
			fzero_q <= (fmag == '0);
			mzero_q <= (divisor == '0);
		end else if (cnt_q != '0) begin
			sh_q <= {sh_q[QW-2:0], 1'b0};
			q_q  <= {q_q[QW-2:0], ge};
			// a zero divisor wraps here, but the result is forced by mzero_q
			r_q  <= ge ? r_sub[W-1:0] : r_try[W-1:0];
		end
	end

	assign done = (cnt_q == '0);
	assign mag  = q_q[W-1:0];
	assign big  = mzero_q || (q_q[QW-1:W] != '0);
	// negative side reaches one step further than positive
	assign over = neg_q ? (mag[W-1] && (mag[W-2:0] != '0)) : mag[W-1];

	always_comb begin
		ovf  = !fzero_q && (big || over);
		quot = neg_q ? W'(-mag) : mag;
		if (fzero_q) begin
			quot = '0;
		end else if (ovf) begin
			quot = neg_q ? WMIN : WMAX;
		end
	end

endmodule

`default_nettype wire

/* sv/pmi_dp.sv */
// Datapath: configuration registers, body state, force accumulator, the
// divider and one shared dt multiplier. Depends on pmi_pkg and pmi_div.
`timescale 1ns / 1ps
`default_nettype none

module pmi_dp import pmi_pkg::*; #(
	parameter int unsigned WORD_BITS = PMI_WORD_BITS,
	parameter int unsigned FRAC_BITS = PMI_FRAC_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [REG_IDX_BITS-1:0]     wr_index,
	input  wire logic [WORD_BITS-1:0]        wr_data,
	input  wire logic signed [WORD_BITS-1:0] force_x,
	input  wire logic signed [WORD_BITS-1:0] force_y,
	input  wire logic signed [WORD_BITS-1:0] force_z,
	input  wire logic                        restart,
	input  wire pmi_cmd_t                    cmd,
	output pmi_stat_t                        stat,
	output logic signed [WORD_BITS-1:0]      pos_x,
	output logic signed [WORD_BITS-1:0]      pos_y,
	output logic signed [WORD_BITS-1:0]      pos_z,
	output logic signed [WORD_BITS-1:0]      vel_x,
	output logic signed [WORD_BITS-1:0]      vel_y,
	output logic signed [WORD_BITS-1:0]      vel_z,
	output logic                             saturated
);
	localparam int unsigned W  = WORD_BITS;
	localparam int unsigned MW = WORD_BITS + DT_BITS - 1;  // multiplier operand
	localparam int unsigned PW = MW + DT_BITS;              // product
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

	// configuration
	logic        [W-1:0]       mass_q;
	logic        [DT_BITS-1:0] dt_q;
	logic signed [W-1:0]       spos_q [NUM_AXES];
	logic signed [W-1:0]       svel_q [NUM_AXES];

	// body state
	logic signed [W-1:0] pos_q [NUM_AXES];
	logic signed [W-1:0] vel_q [NUM_AXES];
	logic signed [W-1:0] fs_q  [NUM_AXES];
	logic                sat_q;

	// per-axis working registers
	logic signed [W-1:0] acc_q;
	logic signed [W:0]   vterm_q;
	logic signed [W:0]   dv_q;
	logic [PW-1:0]       prod_q;

	logic signed [W-1:0] out_pos_q [NUM_AXES];
	logic signed [W-1:0] out_vel_q [NUM_AXES];
	logic                out_sat_q;

	logic signed [W-1:0] frc      [NUM_AXES];
	logic signed [W-1:0] fs_next  [NUM_AXES];
	logic [NUM_AXES-1:0] fs_ovf;
	logic signed [W-1:0] base;
	logic signed [W:0]   fsum;

	logic signed [W-1:0] cur_pos;
	logic signed [W-1:0] cur_vel;
	logic [W-1:0]        vmag;
	logic [W-1:0]        amag;
	logic [MW-1:0]       mul_op;
	logic [PW-1:0]       mul_res;
	logic [W-1:0]        pmag;
	logic [W-3:0]        hmag;
	logic signed [W+1:0] half;
	logic signed [W+1:0] np;
	logic signed [W+1:0] nv;
	logic                np_ovf;
	logic                nv_ovf;
	logic signed [W-1:0] np_sat;
	logic signed [W-1:0] nv_sat;

	logic                div_ovf;
	logic signed [W-1:0] div_quot;

	assign frc[0] = force_x;
	assign frc[1] = force_y;
	assign frc[2] = force_z;

	always_comb begin
		base = '0;
		fsum = '0;
		for (int i = 0; i < NUM_AXES; i++) begin
			base       = restart ? '0 : fs_q[i];
			fsum       = {base[W-1], base} + {frc[i][W-1], frc[i]};
			fs_ovf[i]  = fsum[W] != fsum[W-1];
			fs_next[i] = fs_ovf[i] ? (fsum[W] ? WMIN : WMAX) : fsum[W-1:0];
		end
	end

	pmi_div #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (fs_q[cmd.axis]),
		.divisor  (mass_q),
		.done     (stat.div_done),
		.ovf      (div_ovf),
		.quot     (div_quot)
	);

	assign cur_pos = pos_q[cmd.axis];
	assign cur_vel = vel_q[cmd.axis];
	assign vmag    = cur_vel[W-1] ? W'(-cur_vel) : W'(cur_vel);
	assign amag    = acc_q[W-1] ? W'(-acc_q) : W'(acc_q);

	always_comb begin
		priority if (cmd.mul_acc2) begin
			mul_op = prod_q[MW-1:0];
		end else if (cmd.mul_acc) begin
			mul_op = {{(MW-W){1'b0}}, amag};
		end else begin
			mul_op = {{(MW-W){1'b0}}, vmag};
		end
	end

	assign mul_res = {{DT_BITS{1'b0}}, mul_op} * {{MW{1'b0}}, dt_q};
	assign pmag    = prod_q[W+DT_BITS-1:DT_BITS];

	// a*dt*dt/2 = product >> (2*DT_BITS + 1)
	assign hmag = prod_q[PW-1:2*DT_BITS+1];
	assign half = acc_q[W-1] ? -$signed({4'b0, hmag}) : $signed({4'b0, hmag});
	assign np   = {{2{cur_pos[W-1]}}, cur_pos} + {vterm_q[W], vterm_q} + half;
	assign nv   = {{2{cur_vel[W-1]}}, cur_vel} + {dv_q[W], dv_q};

	assign np_ovf = (np[W+1:W-1] != 3'b000) && (np[W+1:W-1] != 3'b111);
	assign nv_ovf = (nv[W+1:W-1] != 3'b000) && (nv[W+1:W-1] != 3'b111);
	assign np_sat = np_ovf ? (np[W+1] ? WMIN : WMAX) : np[W-1:0];
	assign nv_sat = nv_ovf ? (nv[W+1] ? WMIN : WMAX) : nv[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
			dt_q   <= DT_RESET;
			for (int i = 0; i < NUM_AXES; i++) begin
				spos_q[i] <= '0;
				svel_q[i] <= '0;
			end
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BODY_MASS:   mass_q    <= wr_data;
				REG_TIME_STEP:   dt_q      <= wr_data[DT_BITS-1:0];
				REG_START_POS_X: spos_q[0] <= wr_data;
				REG_START_POS_Y: spos_q[1] <= wr_data;
				REG_START_POS_Z: spos_q[2] <= wr_data;
				REG_START_VEL_X: svel_q[0] <= wr_data;
				REG_START_VEL_Y: svel_q[1] <= wr_data;
				REG_START_VEL_Z: svel_q[2] <= wr_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				fs_q[i]  <= '0;
			end
			sat_q <= 1'b0;
		end else if (cmd.accept) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				fs_q[i] <= fs_next[i];
				if (restart) begin
					pos_q[i] <= spos_q[i];
					vel_q[i] <= svel_q[i];
				end
			end
			sat_q <= |fs_ovf;
		end else if (cmd.mul_vel) begin
			sat_q <= sat_q | div_ovf;
		end else if (cmd.update) begin
			pos_q[cmd.axis] <= np_sat;
			vel_q[cmd.axis] <= nv_sat;
			sat_q           <= sat_q | np_ovf | nv_ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_vel || cmd.mul_acc || cmd.mul_acc2) begin
			prod_q <= mul_res;
		end
		if (cmd.mul_vel) begin
			acc_q <= div_quot;
		end
		if (cmd.mul_acc) begin
			vterm_q <= cur_vel[W-1] ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
		end
		if (cmd.mul_acc2) begin
			dv_q <= acc_q[W-1] ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
		end
		if (cmd.out_load) begin
			out_pos_q <= pos_q;
			out_vel_q <= vel_q;
			out_sat_q <= sat_q;
		end
	end

	assign pos_x     = out_pos_q[0];
	assign pos_y     = out_pos_q[1];
	assign pos_z     = out_pos_q[2];
	assign vel_x     = out_vel_q[0];
	assign vel_y     = out_vel_q[1];
	assign vel_z     = out_vel_q[2];
	assign saturated = out_sat_q;

endmodule

`default_nettype wire

/* sv/pmi_ctrl.sv */
// Controller: sequences force add, per-axis divide and multiply steps, and
// the result register handshake. Depends on pmi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmi_ctrl import pmi_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_advance,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	output pmi_cmd_t       cmd,
	input  wire pmi_stat_t stat
);
	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DSTART = 8'b0000_0010,
		ST_DIV    = 8'b0000_0100,
		ST_MV     = 8'b0000_1000,
		ST_MA     = 8'b0001_0000,
		ST_MA2    = 8'b0010_0000,
		ST_UPD    = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [1:0] axis_q;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_ready && in_valid;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = in_advance ? ST_DSTART : ST_DONE;
			ST_DSTART: state_d = ST_DIV;
			ST_DIV:    if (stat.div_done) state_d = ST_MV;
			ST_MV:     state_d = ST_MA;
			ST_MA:     state_d = ST_MA2;
			ST_MA2:    state_d = ST_UPD;
			ST_UPD:    state_d = (axis_q == AXIS_LAST) ? ST_DONE : ST_DSTART;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.axis      = axis_q;
		cmd.accept    = accept;
		cmd.div_start = (state_q == ST_DSTART);
		cmd.mul_vel   = (state_q == ST_MV);
		cmd.mul_acc   = (state_q == ST_MA);
		cmd.mul_acc2  = (state_q == ST_MA2);
		cmd.update    = (state_q == ST_UPD);
		cmd.out_load  = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= AXIS_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				axis_q <= AXIS_FIRST;
			end else if (state_q == ST_UPD && axis_q != AXIS_LAST) begin
				axis_q <= axis_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_adv_starts_x: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_advance) |=> (state_q == ST_DSTART && axis_q == AXIS_FIRST))
		else $error("advance item did not start the x axis divide");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DSTART) |=> !stat.div_done)
		else $error("divider reports done right after start");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (axis_q != 2'd3))
		else $error("axis counter out of range");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result load did not present a result");

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for point_mass_integrator: a directed table and then random
// force items, all driven over ready/valid and checked against table entries or an in-bench model.
// Depends on pmi_pkg, pmi_item_if, pmi_result_if and the integrator RTL.
`timescale 1ns / 1ps

module testbench;
	import pmi_pkg::*;

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int SETTLE_CYCLES   = 200;   // extra wait after the last expected result has arrived
	localparam int LONG_HOLD       = 600;
	localparam longint WORD_MAX    = 64'sd2147483647;
	localparam longint WORD_MIN    = -64'sd2147483648;

	typedef enum logic {ROW_FORCE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic               advance;
		logic               restart;
	} force_item_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [31:0] vel_z;
		logic        saturated;
	} motion_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [REG_IDX_BITS-1:0] reg_idx;
		logic [31:0]             wr_value;
		force_item_t             stim;
		logic                    typed;
		motion_t                 want;
	} stim_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      wr_en;
	logic [REG_IDX_BITS-1:0]   wr_index;
	logic [PMI_WORD_BITS-1:0]  wr_data;

	pmi_item_if   item_ch ();
	pmi_result_if result_ch ();

	point_mass_integrator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	// model state of the body and its registers
	longint          body_pos [3];
	longint          body_vel [3];
	longint          force_acc [3];
	longint unsigned cfg_mass;
	longint unsigned cfg_dt;
	longint          cfg_start_pos [3];
	longint          cfg_start_vel [3];
	bit              step_clipped;

	motion_t   expected_states [$];
	stim_row_t directed_rows [$];

	int mismatches;
	int results_checked;
	int sat_results;
	int items_sent;
	int advances;
	int restarts;
	int settings_used;
	int burst_left;
	bit long_hold_done;

	always #4 clk = ~clk;

	function automatic longint clip_word(longint v);
		if (v > WORD_MAX) begin
			step_clipped = 1'b1;
			return WORD_MAX;
		end
		if (v < WORD_MIN) begin
			step_clipped = 1'b1;
			return WORD_MIN;
		end
		return v;
	endfunction

	// acceleration = force * 2^16 / mass, truncated toward zero, saturated
	function automatic longint accel_of_force(longint f, longint unsigned mass);
		longint unsigned mag;
		longint unsigned quo;
		mag = (f < 0) ? -f : f;
		if (mag == 0)
			return 0;
		if (mass == 0) begin
			step_clipped = 1'b1;
			return (f < 0) ? WORD_MIN : WORD_MAX;
		end
		quo = (mag << PMI_FRAC_BITS) / mass;
		if (quo > 64'hFFFF_FFFF) begin
			step_clipped = 1'b1;
			return (f < 0) ? WORD_MIN : WORD_MAX;
		end
		return clip_word((f < 0) ? -longint'(quo) : longint'(quo));
	endfunction

	// x*dt / 2^16 toward zero
	function automatic longint dt_term(longint x, longint unsigned dt);
		longint unsigned mag;
		longint unsigned r;
		mag = (x < 0) ? -x : x;
		r = (mag * dt) >> DT_BITS;
		return (x < 0) ? -longint'(r) : longint'(r);
	endfunction

	// x*dt*dt / 2^33 toward zero; the product stays below 2^63
	function automatic longint half_dt2_term(longint x, longint unsigned dt);
		longint unsigned mag;
		longint unsigned r;
		mag = (x < 0) ? -x : x;
		r = (mag * dt * dt) >> 33;
		return (x < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic motion_t integrate_item(force_item_t it);
		longint          f [3];
		longint          a;
		longint          np;
		longint          nv;
		motion_t         m;
		f[0] = longint'(it.force_x);
		f[1] = longint'(it.force_y);
		f[2] = longint'(it.force_z);
		step_clipped = 1'b0;
		if (it.restart) begin
			for (int i = 0; i < 3; i++) begin
				body_pos[i]  = cfg_start_pos[i];
				body_vel[i]  = cfg_start_vel[i];
				force_acc[i] = 0;
			end
		end
		for (int i = 0; i < 3; i++)
			force_acc[i] = clip_word(force_acc[i] + f[i]);
		if (it.advance) begin
			for (int i = 0; i < 3; i++) begin
				a  = accel_of_force(force_acc[i], cfg_mass);
				np = body_pos[i] + dt_term(body_vel[i], cfg_dt) + half_dt2_term(a, cfg_dt);
				nv = body_vel[i] + dt_term(a, cfg_dt);
				body_pos[i] = clip_word(np);
				body_vel[i] = clip_word(nv);
			end
		end
		m.pos_x     = body_pos[0][31:0];
		m.pos_y     = body_pos[1][31:0];
		m.pos_z     = body_pos[2][31:0];
		m.vel_x     = body_vel[0][31:0];
		m.vel_y     = body_vel[1][31:0];
		m.vel_z     = body_vel[2][31:0];
		m.saturated = step_clipped;
		return m;
	endfunction

	function automatic motion_t kinematics(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
		logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic sat);
		motion_t m;
		m = '{px, py, pz, vx, vy, vz, sat};
		return m;
	endfunction

	function automatic stim_row_t row_write(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value);
		stim_row_t r;
		r          = '0;
		r.kind     = ROW_WRITE;
		r.reg_idx  = idx;
		r.wr_value = value;
		return r;
	endfunction

	function automatic stim_row_t row_force(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
		logic adv, logic rst);
		stim_row_t r;
		r      = '0;
		r.kind = ROW_FORCE;
		r.stim = '{fx, fy, fz, adv, rst};
		return r;
	endfunction

	function automatic stim_row_t row_checked(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
		logic adv, logic rst, motion_t want);
		stim_row_t r;
		r       = row_force(fx, fy, fz, adv, rst);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	function automatic logic [31:0] pick_word();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return 32'h7FFF_FFFF;
		if (sel == 1)
			return 32'h8000_0000;
		if (sel == 2)
			return '0;
		if (sel < 7)
			return $urandom;
		// small values, within about +-16.0
		return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
	endfunction

	task automatic hold_sender(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
		end
	endtask

	task automatic wait_idle();
		hold_sender(1);
		while (expected_states.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_register(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		case (idx)
			REG_BODY_MASS:   cfg_mass = 64'(value);
			REG_TIME_STEP:   cfg_dt = 64'(value[DT_BITS-1:0]);
			REG_START_POS_X: cfg_start_pos[0] = longint'($signed(value));
			REG_START_POS_Y: cfg_start_pos[1] = longint'($signed(value));
			REG_START_POS_Z: cfg_start_pos[2] = longint'($signed(value));
			REG_START_VEL_X: cfg_start_vel[0] = longint'($signed(value));
			REG_START_VEL_Y: cfg_start_vel[1] = longint'($signed(value));
			REG_START_VEL_Z: cfg_start_vel[2] = longint'($signed(value));
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// bursts of random length, mostly separated by random gaps
	task automatic pace_sender();
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0)
				hold_sender($urandom_range(1, 8));
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
	endtask

	task automatic offer_item(force_item_t it, bit typed, motion_t typed_state);
		motion_t predicted;
		pace_sender();
		@(negedge clk);
		item_ch.valid   <= 1'b1;
		item_ch.force_x <= it.force_x;
		item_ch.force_y <= it.force_y;
		item_ch.force_z <= it.force_z;
		item_ch.advance <= it.advance;
		item_ch.restart <= it.restart;
		do @(posedge clk); while (!item_ch.ready);
		predicted = integrate_item(it);
		expected_states.push_back(typed ? typed_state : predicted);
		items_sent++;
		if (it.advance)
			advances++;
		if (it.restart)
			restarts++;
	endtask

	task automatic configure_phase(int phase);
		logic [31:0] mass;
		logic [31:0] step;
		case (phase)
			0: begin
				mass = 32'd1;
				step = 32'd1;
			end
			1: begin
				mass = 32'hFFFF_FFFF;
				step = 32'h0000_FFFF;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: mass = 32'h0001_0000;
					1: mass = $urandom_range(1, 32'h000F_FFFF);
					2: mass = $urandom_range(1, 32'hFFFF_FFFF);
					default: mass = $urandom_range(1, 255);
				endcase
				case ($urandom_range(0, 3))
					0: step = 32'(DT_RESET);
					1: step = $urandom_range(1, 65535);
					2: step = $urandom_range(1, 64);
					default: step = 32'h0000_FFFF;
				endcase
			end
		endcase
		wait_idle();
		set_register(REG_BODY_MASS, mass);
		set_register(REG_TIME_STEP, step);
		set_register(REG_START_POS_X, pick_word());
		set_register(REG_START_POS_Y, pick_word());
		set_register(REG_START_POS_Z, pick_word());
		set_register(REG_START_VEL_X, pick_word());
		set_register(REG_START_VEL_Y, pick_word());
		set_register(REG_START_VEL_Z, pick_word());
		settings_used++;
	endtask

	// result checker
	always @(posedge clk) begin
		motion_t got;
		motion_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = '{result_ch.pos_x, result_ch.pos_y, result_ch.pos_z,
				result_ch.vel_x, result_ch.vel_y, result_ch.vel_z, result_ch.saturated};
			if (got.saturated)
				sat_results++;
			if (expected_states.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer at %0t: pos %h %h %h vel %h %h %h sat %b",
						$realtime, got.pos_x, got.pos_y, got.pos_z,
						got.vel_x, got.vel_y, got.vel_z, got.saturated);
			end else begin
				want = expected_states.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch on result %0d at %0t", results_checked, $realtime);
						$display("  expected pos %h %h %h vel %h %h %h sat %b",
							want.pos_x, want.pos_y, want.pos_z,
							want.vel_x, want.vel_y, want.vel_z, want.saturated);
						$display("  actual   pos %h %h %h vel %h %h %h sat %b",
							got.pos_x, got.pos_y, got.pos_z,
							got.vel_x, got.vel_y, got.vel_z, got.saturated);
					end
				end
			end
			results_checked++;
		end
	end

	// receiver: ready pattern is picked anew at random, plus one long hold to back up the block
	initial begin
		int mode;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!long_hold_done && results_checked >= 300) begin
				long_hold_done = 1'b1;
				@(negedge clk);
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			mode = $urandom_range(0, 2);
			repeat (32) begin
				@(negedge clk);
				case (mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= ($urandom_range(0, 1) == 1);
					default: result_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		#5_000_000;
		$display("timeout: %0d results still outstanding", expected_states.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		force_item_t it;
		motion_t     unused;
		row_kind_t   last_kind;
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		wr_index        = '0;
		wr_data         = '0;
		item_ch.valid   = 1'b0;
		item_ch.force_x = '0;
		item_ch.force_y = '0;
		item_ch.force_z = '0;
		item_ch.advance = 1'b0;
		item_ch.restart = 1'b0;
		unused          = '0;
		last_kind       = ROW_FORCE;

		cfg_mass = 64'h0001_0000;
		cfg_dt   = 64'(DT_RESET);
		for (int i = 0; i < 3; i++) begin
			body_pos[i]      = 0;
			body_vel[i]      = 0;
			force_acc[i]     = 0;
			cfg_start_pos[i] = 0;
			cfg_start_vel[i] = 0;
		end
		settings_used = 1;

		directed_rows = '{
			// defaults after reset: everything at rest
			row_checked('0, '0, '0, 1'b0, 1'b0, kinematics('0, '0, '0, '0, '0, '0, 1'b0)),
			row_checked(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1'b0, 1'b0,
				kinematics('0, '0, '0, '0, '0, '0, 1'b0)),
			// accumulator pushed past both limits
			row_checked(32'h1, 32'hFFFF_FFFF, '0, 1'b0, 1'b0,
				kinematics('0, '0, '0, '0, '0, '0, 1'b1)),
			row_force('0, '0, '0, 1'b1, 1'b0),
			row_force('0, '0, '0, 1'b1, 1'b0),
			row_checked('0, '0, '0, 1'b0, 1'b1, kinematics('0, '0, '0, '0, '0, '0, 1'b0)),
			row_write(REG_START_POS_X, 32'h7FFF_FFFF),
			row_write(REG_START_POS_Y, 32'h8000_0000),
			row_write(REG_START_POS_Z, 32'h0001_2345),
			row_write(REG_START_VEL_X, 32'h7FFF_FFFF),
			row_write(REG_START_VEL_Y, 32'h8000_0000),
			row_write(REG_START_VEL_Z, 32'hFFFF_0000),
			row_write(REG_TIME_STEP, 32'h0000_FFFF),
			row_write(REG_BODY_MASS, 32'h0000_0001),
			row_checked('0, '0, '0, 1'b0, 1'b1, kinematics(32'h7FFF_FFFF, 32'h8000_0000,
				32'h0001_2345, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 1'b0)),
			// tiny mass: quotient overflows, position runs into the rails
			row_force(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1'b1, 1'b1),
			row_force('0, '0, '0, 1'b1, 1'b0),
			// zero mass
			row_write(REG_BODY_MASS, 32'h0),
			row_write(REG_TIME_STEP, 32'h0000_028F),
			row_force(32'h0000_0064, 32'hFFFF_FF9C, '0, 1'b1, 1'b1),
			// zero time step leaves the start state untouched
			row_write(REG_BODY_MASS, 32'hFFFF_FFFF),
			row_write(REG_TIME_STEP, 32'h0),
			row_checked(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345, 1'b1, 1'b1,
				kinematics(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345,
				32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 1'b0)),
			row_write(REG_TIME_STEP, 32'h1),
			row_write(REG_BODY_MASS, 32'h0001_0000),
			row_write(REG_START_POS_X, 32'h0001_0000),
			row_write(REG_START_POS_Y, 32'hFFFF_0000),
			row_write(REG_START_POS_Z, 32'h0),
			row_write(REG_START_VEL_X, 32'h0000_8000),
			row_write(REG_START_VEL_Y, 32'h0),
			row_write(REG_START_VEL_Z, 32'hFFF0_0000),
			row_force(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 1'b1, 1'b1),
			row_force(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b1, 1'b0),
			row_force('0, '0, '0, 1'b0, 1'b0),
			row_write(REG_TIME_STEP, 32'h0000_8000),
			row_write(REG_BODY_MASS, 32'h0000_0100),
			row_force(32'h0040_0000, 32'hFFC0_0000, '0, 1'b1, 1'b1),
			row_force(32'h0040_0000, 32'hFFC0_0000, 32'h7FFF_FFFF, 1'b1, 1'b0),
			row_force('0, '0, '0, 1'b1, 1'b0)
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_WRITE) begin
				if (last_kind == ROW_FORCE) begin
					wait_idle();
					settings_used++;
				end
				set_register(directed_rows[r].reg_idx, directed_rows[r].wr_value);
			end else begin
				offer_item(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);
			end
			last_kind = directed_rows[r].kind;
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			configure_phase(phase);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				it.force_x = pick_word();
				it.force_y = pick_word();
				it.force_z = pick_word();
				it.advance = 1'($urandom_range(0, 1));
				it.restart = ($urandom_range(0, 11) == 0);
				offer_item(it, 1'b0, unused);
				// now and then let the pipeline drain completely
				if ($urandom_range(0, 49) == 0)
					wait_idle();
			end
		end

		hold_sender(1);
		while (expected_states.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d force items (%0d advancing, %0d restarting) over %0d register settings",
			items_sent, advances, restarts, settings_used);
		$display("%0d results checked, %0d with saturation, %0d mismatches",
			results_checked, sat_results, mismatches);
		if (mismatches == 0 && expected_states.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
sv/pmi_pkg.sv
sv/pmi_item_if.sv
sv/pmi_result_if.sv
sv/pmi_div.sv
sv/pmi_dp.sv
sv/pmi_ctrl.sv
sv/point_mass_integrator.sv
dv/testbench.sv
